// ----- rtl/adu_pkg.sv -----
// adu_pkg: shared types, mode codes and constants of the activation unit
// no dependencies; used by every rtl module of the block, not by the two interfaces
package adu_pkg;

  // default fraction width of the value and activation fields
  localparam int unsigned FRAC_BITS = 16;

  // exponential series and divider sizing
  localparam int unsigned EXP_TERMS = 14;
  localparam int unsigned RED_STEPS = 3;
  localparam int unsigned QW        = 31;
  localparam int unsigned DIV_W     = 64;

  localparam logic [37:0] LN2_Q32  = 38'd2977044472;
  localparam logic [16:0] DER_ONE  = 17'd65536;
  localparam logic [9:0]  LEAK_NUM = 10'd655;

  typedef enum logic [2:0] {
    MODE_SIGMOID   = 3'd0,
    MODE_RELU      = 3'd1,
    MODE_LINEAR    = 3'd2,
    MODE_THRESHOLD = 3'd3,
    MODE_LEAKY     = 3'd4,
    MODE_TANH      = 3'd5
  } mode_e;

  // per-item side data that travels alongside the arithmetic
  typedef struct packed {
    mode_e       mode;
    logic        neg;
    logic        sat;
    logic [5:0]  n;
    logic [31:0] act;
    logic [16:0] der;
  } side_t;

endpackage

// ----- rtl/adu_in_if.sv -----
// adu_in_if: input channel carrying one pre-activation value per transfer
// depends on nothing
interface adu_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/adu_out_if.sv -----
// adu_out_if: output channel carrying activation and derivative per transfer
// depends on nothing
interface adu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] activation;
  logic        [16:0] derivative;

  modport source (output valid, output activation, output derivative, input ready);
  modport sink   (input valid, input activation, input derivative, output ready);
endinterface

// ----- rtl/adu_reduce.sv -----
// adu_reduce: range reduction a = n*ln2 + r, two quotient bits per stage
// depends on adu_pkg
module adu_reduce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  logic [36:0]     a_i,
  input  adu_pkg::side_t  side_i,
  output logic            vld_o,
  output logic [31:0]     r_o,
  output adu_pkg::side_t  side_o
);

  localparam int unsigned NS = adu_pkg::RED_STEPS;

  logic [36:0]    rem_q  [NS];
  logic [5:0]     n_q    [NS];
  logic           vld_q  [NS];
  adu_pkg::side_t side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    localparam int unsigned HI = 5 - 2 * s;
    localparam int unsigned LO = 4 - 2 * s;
    localparam logic [37:0] LS_HI = adu_pkg::LN2_Q32 << HI;
    localparam logic [37:0] LS_LO = adu_pkg::LN2_Q32 << LO;

    logic [36:0]    rin;
    logic [5:0]     nin;
    logic           vin;
    adu_pkg::side_t sin;
    logic [36:0]    rem_d;
    logic [5:0]     n_d;

    if (s == 0) begin : g_first
      assign rin = a_i;
      assign nin = 6'd0;
      assign vin = vld_i;
      assign sin = side_i;
    end else begin : g_next
      assign rin = rem_q[s-1];
      assign nin = n_q[s-1];
      assign vin = vld_q[s-1];
      assign sin = side_q[s-1];
    end

    // two restoring compare-subtract steps
    always_comb begin
      logic [36:0] r1;
      logic [5:0]  n1;
      r1 = rin;
      n1 = nin;
      if (38'(r1) >= LS_HI) begin
        r1 = r1 - LS_HI[36:0];
        n1[HI] = 1'b1;
      end
      if (38'(r1) >= LS_LO) begin
        r1 = r1 - LS_LO[36:0];
        n1[LO] = 1'b1;
      end
      rem_d = r1;
      n_d   = n1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        n_q[s]    <= n_d;
        side_q[s] <= sin;
      end
    end
  end

  // remainder is below ln2 and fits 32 bits
  always_comb begin
    side_o   = side_q[NS-1];
    side_o.n = n_q[NS-1];
  end
  assign vld_o = vld_q[NS-1];
  assign r_o   = rem_q[NS-1][31:0];

endmodule

// ----- rtl/adu_series.sv -----
// adu_series: exp(-r) in q32 by an alternating series, three stages per term
// depends on adu_pkg
module adu_series (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  logic [31:0]     r_i,
  input  adu_pkg::side_t  side_i,
  output logic            vld_o,
  output logic [33:0]     sum_o,
  output adu_pkg::side_t  side_o
);

  localparam int unsigned NT = adu_pkg::EXP_TERMS;

  // stage a: product, stage b: reciprocal quotient, stage c: corrected term
  logic           a_vld_q [NT];
  logic [31:0]    a_p_q   [NT];
  logic [31:0]    a_r_q   [NT];
  logic [33:0]    a_sum_q [NT];
  adu_pkg::side_t a_side_q[NT];
  logic           b_vld_q [NT];
  logic [31:0]    b_p_q   [NT];
  logic [31:0]    b_q0_q  [NT];
  logic [31:0]    b_r_q   [NT];
  logic [33:0]    b_sum_q [NT];
  adu_pkg::side_t b_side_q[NT];
  logic           c_vld_q [NT];
  logic [32:0]    c_term_q[NT];
  logic [31:0]    c_r_q   [NT];
  logic [33:0]    c_sum_q [NT];
  adu_pkg::side_t c_side_q[NT];

  for (genvar k = 0; k < NT; k++) begin : g_term
    localparam int unsigned KDIV = k + 1;
    localparam logic [32:0] MUL  = 33'((65'd1 << 32) / KDIV);
    localparam logic [3:0]  KV   = 4'(k + 1);

    logic           vin;
    logic [32:0]    tin;
    logic [31:0]    rin;
    logic [33:0]    sin_sum;
    adu_pkg::side_t sin;
    logic [64:0]    prod_a;
    logic [64:0]    prod_b;
    logic [35:0]    qk;
    logic [31:0]    rem;
    logic [31:0]    q;
    logic [33:0]    sum_d;

    if (k == 0) begin : g_first
      assign vin     = vld_i;
      assign tin     = 33'h1_0000_0000;
      assign rin     = r_i;
      assign sin_sum = 34'h1_0000_0000;
      assign sin     = side_i;
    end else begin : g_next
      assign vin     = c_vld_q[k-1];
      assign tin     = c_term_q[k-1];
      assign rin     = c_r_q[k-1];
      assign sin_sum = c_sum_q[k-1];
      assign sin     = c_side_q[k-1];
    end

    // term times r, back in q32
    assign prod_a = 65'(tin) * 65'(rin);
    // quotient estimate by reciprocal, at most one low
    assign prod_b = 65'(a_p_q[k]) * 65'(MUL);
    // correction and accumulate with alternating sign
    assign qk  = 36'(b_q0_q[k]) * 36'(KV);
    assign rem = b_p_q[k] - qk[31:0];
    assign q   = (rem >= 32'(KV)) ? b_q0_q[k] + 32'd1 : b_q0_q[k];
    assign sum_d = (KDIV % 2 == 1) ? b_sum_q[k] - 34'(q) : b_sum_q[k] + 34'(q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q[k] <= 1'b0;
        b_vld_q[k] <= 1'b0;
        c_vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        a_vld_q[k] <= vin;
        b_vld_q[k] <= a_vld_q[k];
        c_vld_q[k] <= b_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        a_p_q[k]    <= prod_a[63:32];
        a_r_q[k]    <= rin;
        a_sum_q[k]  <= sin_sum;
        a_side_q[k] <= sin;
        b_p_q[k]    <= a_p_q[k];
        b_q0_q[k]   <= prod_b[63:32];
        b_r_q[k]    <= a_r_q[k];
        b_sum_q[k]  <= a_sum_q[k];
        b_side_q[k] <= a_side_q[k];
        c_term_q[k] <= 33'(q);
        c_r_q[k]    <= b_r_q[k];
        c_sum_q[k]  <= sum_d;
        c_side_q[k] <= b_side_q[k];
      end
    end
  end

  assign vld_o  = c_vld_q[NT-1];
  assign sum_o  = c_sum_q[NT-1];
  assign side_o = c_side_q[NT-1];

endmodule

// ----- rtl/adu_divider.sv -----
// adu_divider: two restoring dividers sharing one divisor, one quotient bit per stage
// depends on adu_pkg
module adu_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      vld_i,
  input  logic [adu_pkg::DIV_W-1:0] na_i,
  input  logic [adu_pkg::DIV_W-1:0] nb_i,
  input  logic [33:0]               d_i,
  input  adu_pkg::side_t            side_i,
  output logic                      vld_o,
  output logic [adu_pkg::QW-1:0]    qa_o,
  output logic [adu_pkg::QW-1:0]    qb_o,
  output adu_pkg::side_t            side_o
);

  localparam int unsigned NQ = adu_pkg::QW;
  localparam int unsigned DW = adu_pkg::DIV_W;

  logic [DW-1:0]  ra_q   [NQ];
  logic [DW-1:0]  rb_q   [NQ];
  logic [NQ-1:0]  qa_q   [NQ];
  logic [NQ-1:0]  qb_q   [NQ];
  logic [33:0]    d_q    [NQ];
  logic           vld_q  [NQ];
  adu_pkg::side_t side_q [NQ];

  for (genvar i = 0; i < NQ; i++) begin : g_st
    localparam int unsigned J = NQ - 1 - i;

    logic           vin;
    logic [DW-1:0]  rain;
    logic [DW-1:0]  rbin;
    logic [NQ-1:0]  qain;
    logic [NQ-1:0]  qbin;
    logic [33:0]    din;
    adu_pkg::side_t sin;
    logic [DW-1:0]  dsh;
    logic           ta;
    logic           tb;

    if (i == 0) begin : g_first
      assign vin  = vld_i;
      assign rain = na_i;
      assign rbin = nb_i;
      assign qain = '0;
      assign qbin = '0;
      assign din  = d_i;
      assign sin  = side_i;
    end else begin : g_next
      assign vin  = vld_q[i-1];
      assign rain = ra_q[i-1];
      assign rbin = rb_q[i-1];
      assign qain = qa_q[i-1];
      assign qbin = qb_q[i-1];
      assign din  = d_q[i-1];
      assign sin  = side_q[i-1];
    end

    // compare against the shifted divisor
    assign dsh = DW'(din) << J;
    assign ta  = (rain >= dsh);
    assign tb  = (rbin >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ra_q[i]   <= ta ? rain - dsh : rain;
        rb_q[i]   <= tb ? rbin - dsh : rbin;
        qa_q[i]   <= qain | (NQ'(ta) << J);
        qb_q[i]   <= qbin | (NQ'(tb) << J);
        d_q[i]    <= din;
        side_q[i] <= sin;
      end
    end
  end

  assign vld_o  = vld_q[NQ-1];
  assign qa_o   = qa_q[NQ-1];
  assign qb_o   = qb_q[NQ-1];
  assign side_o = side_q[NQ-1];

endmodule

// ----- rtl/activation_and_derivative_unit.sv -----
// Activation and derivative unit: one signed fixed-point value in per transfer, the
// selected activation and its derivative (16 fraction bits) out. The pipeline takes
// one item every cycle when no output stall freezes the pipeline. Stages: input,
// three range reduction, three for each of the 14 exponential series terms,
// numerator, 31 divider (one quotient bit each), multiply and output register.
// The user writes the mode register through cfg_we_i/cfg_data_i only while the
// pipeline is empty; the block itself does not enforce this.
module activation_and_derivative_unit #(
  parameter int unsigned FRAC_BITS = adu_pkg::FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_data_i,
  adu_in_if.sink     in_i,
  adu_out_if.source  out_o
);

  localparam int unsigned SH = 32 - FRAC_BITS;
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

  logic adv;

  // mode register
  adu_pkg::mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= adu_pkg::MODE_LINEAR;
    end else if (cfg_we_i) begin
      mode_q <= adu_pkg::mode_e'(cfg_data_i);
    end
  end

  // input stage: magnitude, exponent argument and the simple functions
  logic [31:0]    xu;
  logic [31:0]    mag;
  logic [63:0]    a64;
  logic [40:0]    leak_p;
  logic [41:0]    leak_q;
  adu_pkg::side_t s0_side_d;
  logic           s0_vld_q;
  logic [36:0]    s0_a_q;
  adu_pkg::side_t s0_side_q;

  assign xu     = in_i.value;
  assign mag    = xu[31] ? (~xu + 32'd1) : xu;
  assign leak_p = 41'(mag) * 41'(adu_pkg::LEAK_NUM);
  assign leak_q = (42'(leak_p) + 42'd65535) >> 16;

  always_comb begin
    a64 = 64'(mag) << SH;
    if (mode_q == adu_pkg::MODE_TANH) begin
      a64 = a64 << 1;
    end
    s0_side_d.mode = mode_q;
    s0_side_d.neg  = xu[31];
    s0_side_d.sat  = |a64[63:37];
    s0_side_d.n    = 6'd0;
    s0_side_d.act  = xu;
    s0_side_d.der  = adu_pkg::DER_ONE;
    case (mode_q)
      adu_pkg::MODE_RELU: begin
        s0_side_d.act = xu[31] ? 32'd0 : xu;
        s0_side_d.der = (!xu[31] && (xu != 32'd0)) ? adu_pkg::DER_ONE : 17'd0;
      end
      adu_pkg::MODE_THRESHOLD: begin
        s0_side_d.act = ($signed(xu) <= HALF) ? 32'd0 : ONE;
      end
      adu_pkg::MODE_LEAKY: begin
        if (xu[31]) begin
          s0_side_d.act = ~leak_q[31:0] + 32'd1;
        end
        s0_side_d.der = (!xu[31] && (xu != 32'd0)) ? adu_pkg::DER_ONE
                                                   : 17'(adu_pkg::LEAK_NUM);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_a_q    <= a64[36:0];
      s0_side_q <= s0_side_d;
    end
  end

  // range reduction
  logic           red_vld;
  logic [31:0]    red_r;
  adu_pkg::side_t red_side;

  adu_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s0_vld_q),
    .a_i    (s0_a_q),
    .side_i (s0_side_q),
    .vld_o  (red_vld),
    .r_o    (red_r),
    .side_o (red_side)
  );

  // exponential series
  logic           ser_vld;
  logic [33:0]    ser_sum;
  adu_pkg::side_t ser_side;

  adu_series u_series (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (red_vld),
    .r_i    (red_r),
    .side_i (red_side),
    .vld_o  (ser_vld),
    .sum_o  (ser_sum),
    .side_o (ser_side)
  );

  // numerator stage: scale by 2^-n and form rounded division operands
  logic [32:0]               e_val;
  logic [32:0]               num;
  logic [33:0]               den;
  logic [63:0]               half;
  logic [63:0]               na_d;
  logic [63:0]               nb_d;
  logic                      nu_vld_q;
  logic [63:0]               nu_na_q;
  logic [63:0]               nu_nb_q;
  logic [33:0]               nu_d_q;
  adu_pkg::side_t            nu_side_q;

  assign e_val = ser_side.sat ? 33'd0 : 33'(ser_sum >> ser_side.n);
  assign num   = 33'h1_0000_0000 - e_val;
  assign den   = 34'h1_0000_0000 + 34'(e_val);
  assign half  = 64'(den >> 1);

  always_comb begin
    if (ser_side.mode == adu_pkg::MODE_TANH) begin
      na_d = (64'(num) << FRAC_BITS) + half;
      nb_d = (64'(num) << 30) + half;
    end else begin
      na_d = ser_side.neg ? (64'(e_val) << FRAC_BITS) + half
                          : (64'd1 << (FRAC_BITS + 32)) + half;
      nb_d = (64'd1 << 62) + half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_vld_q <= 1'b0;
    end else if (adv) begin
      nu_vld_q <= ser_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nu_na_q   <= na_d;
      nu_nb_q   <= nb_d;
      nu_d_q    <= den;
      nu_side_q <= ser_side;
    end
  end

  // dividers
  logic                   div_vld;
  logic [adu_pkg::QW-1:0] div_qa;
  logic [adu_pkg::QW-1:0] div_qb;
  adu_pkg::side_t         div_side;

  adu_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (nu_vld_q),
    .na_i   (nu_na_q),
    .nb_i   (nu_nb_q),
    .d_i    (nu_d_q),
    .side_i (nu_side_q),
    .vld_o  (div_vld),
    .qa_o   (div_qa),
    .qb_o   (div_qb),
    .side_o (div_side)
  );

  // multiply stage: s(1-s) or t^2 in q60
  logic [adu_pkg::QW-1:0] mul_b;
  logic [61:0]            prod_d;
  logic                   mu_vld_q;
  logic [61:0]            mu_prod_q;
  logic [adu_pkg::QW-1:0] mu_qa_q;
  adu_pkg::side_t         mu_side_q;

  assign mul_b  = (div_side.mode == adu_pkg::MODE_TANH) ? div_qb
                                                        : (31'h4000_0000 - div_qb);
  assign prod_d = 62'(div_qb) * 62'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_vld_q <= 1'b0;
    end else if (adv) begin
      mu_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_prod_q <= prod_d;
      mu_qa_q   <= div_qa;
      mu_side_q <= div_side;
    end
  end

  // output stage: rounding and final selection
  logic [62:0]    rnd_sum;
  logic [17:0]    rnd;
  logic [31:0]    act_d;
  logic [16:0]    der_d;
  logic           out_vld_q;
  logic [31:0]    out_act_q;
  logic [16:0]    out_der_q;
  adu_pkg::mode_e out_mode_q;

  assign rnd_sum = 63'(mu_prod_q) + (63'd1 << 43);
  assign rnd     = rnd_sum[61:44];

  always_comb begin
    act_d = mu_side_q.act;
    der_d = mu_side_q.der;
    case (mu_side_q.mode)
      adu_pkg::MODE_SIGMOID: begin
        act_d = 32'(mu_qa_q);
        der_d = rnd[16:0];
      end
      adu_pkg::MODE_TANH: begin
        act_d = mu_side_q.neg ? (~32'(mu_qa_q) + 32'd1) : 32'(mu_qa_q);
        der_d = (rnd >= 18'(adu_pkg::DER_ONE)) ? 17'd0 : adu_pkg::DER_ONE - rnd[16:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= mu_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_act_q  <= act_d;
      out_der_q  <= der_d;
      out_mode_q <= mu_side_q.mode;
    end
  end

  // pipeline advances unless a finished result is held
  assign adv              = !out_vld_q || out_o.ready;
  assign in_i.ready       = adv;
  assign out_o.valid      = out_vld_q;
  assign out_o.activation = out_act_q;
  assign out_o.derivative = out_der_q;

  // a stall never drops an item from the first stage
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_vld_q && !adv) |=> s0_vld_q)
    else $error("item lost from input stage during stall");

  // derivative never exceeds one
  a_der_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.derivative <= adu_pkg::DER_ONE))
    else $error("derivative above one");

  // sigmoid and tanh stay within plus or minus one
  a_act_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_mode_q == adu_pkg::MODE_SIGMOID ||
                     out_mode_q == adu_pkg::MODE_TANH))
    |-> ($signed(out_o.activation) <= ONE && $signed(out_o.activation) >= -ONE))
    else $error("bounded activation out of range");

endmodule

// ----- tb/tb_activation_and_derivative_unit.sv -----
// tb_activation_and_derivative_unit: self-checking bench for the activation unit,
// predicting activation and derivative per value and checking every result in order
// depends on adu_pkg, adu_in_if, adu_out_if and activation_and_derivative_unit
module tb_activation_and_derivative_unit;

  localparam logic [2:0] MODE_IDENT_B = 3'd7;
  localparam int unsigned FB         = adu_pkg::FRAC_BITS;
  localparam int unsigned PIPE_LAT   = 80;
  localparam int unsigned DRAIN_WAIT = 2 * PIPE_LAT;
  localparam int unsigned WDOG_LIMIT = 5000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned PHASE_RAND = 200;

  typedef struct {
    logic signed [31:0] act;
    logic        [16:0] der;
  } act_der_t;

  // exp(-a), a and result in Q32
  function automatic longint unsigned exp_neg(longint unsigned a);
    longint unsigned n, r, term, sum;
    if (a >= (64'd32 << 32)) return 0;
    n = a / 64'd2977044472;
    r = a - n * 64'd2977044472;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * r) >> 32) / k;
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return sum >> n;
  endfunction

  class act_scoreboard;
    logic [2:0] mode;
    act_der_t   pending[$];
    int         errors;
    int         checked;

    function new();
      mode = adu_pkg::MODE_LINEAR;
      errors = 0;
      checked = 0;
    endfunction

    function act_der_t compute(logic signed [31:0] value);
      act_der_t res;
      longint x, act;
      longint unsigned mag, a32, one, der, e, d, sp, sp30, sn30, num, t, t30, sq;
      x = value;
      mag = (x < 0) ? -x : x;
      a32 = mag << (32 - FB);
      one = 64'd1 << FB;
      act = x;
      der = 65536;
      case (mode)
        adu_pkg::MODE_SIGMOID: begin
          e = exp_neg(a32);
          d = (64'd1 << 32) + e;
          if (x >= 0) sp = ((64'd1 << (FB + 32)) + d / 2) / d;
          else sp = ((e << FB) + d / 2) / d;
          act = sp;
          sp30 = ((64'd1 << 62) + d / 2) / d;
          sn30 = (64'd1 << 30) - sp30;
          der = (sp30 * sn30 + (64'd1 << 43)) >> 44;
        end
        adu_pkg::MODE_RELU: begin
          act = (x < 0) ? 0 : x;
          der = (x > 0) ? 65536 : 0;
        end
        adu_pkg::MODE_THRESHOLD: act = (x <= longint'(one >> 1)) ? 0 : longint'(one);
        adu_pkg::MODE_LEAKY: begin
          if (x < 0) act = -longint'((mag * 655 + 65535) >> 16);
          der = (x > 0) ? 65536 : 655;
        end
        adu_pkg::MODE_TANH: begin
          e = exp_neg(a32 << 1);
          d = (64'd1 << 32) + e;
          num = (64'd1 << 32) - e;
          t = ((num << FB) + d / 2) / d;
          t30 = ((num << 30) + d / 2) / d;
          sq = (t30 * t30 + (64'd1 << 43)) >> 44;
          act = (x < 0) ? -longint'(t) : longint'(t);
          der = (sq >= 65536) ? 0 : 65536 - sq;
        end
        default: ;
      endcase
      res.act = act[31:0];
      res.der = der[16:0];
      return res;
    endfunction

    function void note_value(logic signed [31:0] value);
      pending = {pending, compute(value)};
    endfunction

    function void check_result(logic signed [31:0] act, logic [16:0] der);
      act_der_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing pending: activation %0d derivative %0d", act, der);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (act !== exp_r.act) begin
        $error("activation: expected %0d, got %0d", exp_r.act, act);
        errors++;
      end
      if (der !== exp_r.der) begin
        $error("derivative: expected %0d, got %0d", exp_r.der, der);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_data_i = '0;

  adu_in_if  in_ch();
  adu_out_if out_ch();

  activation_and_derivative_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  act_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_busy = 1'b0;
  int  quiet_cycles = 0;
  int  sent = 0;

  // clock
  always #5 clk_i = ~clk_i;

  // note every accepted input, check every accepted result
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) sb.note_value(in_ch.value);
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.activation, out_ch.derivative);
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_busy) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one long hold-off counted here while the sender keeps offering
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_busy = 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_busy = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("tb_activation_and_derivative_unit: errors");
      $finish;
    end
  end

  // offer one value, idling at random first, until the transfer happens
  task automatic send_value(logic signed [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= $urandom;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // random value biased toward the interesting regions
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: v = $urandom;
      3, 4, 5: v = $urandom_range(0, 40 << 16);
      6: v = 32768 + $urandom_range(0, 16) - 8;
      7: v = (32 << 16) + $urandom_range(0, 6) - 3;
      8: v = (16 << 16) + $urandom_range(0, 6) - 3;
      default: v = $urandom_range(0, 40);
    endcase
    if (sel >= 3 && sel != 6 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // wait until every expected result is back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || hold_busy) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [2:0] m);
    cfg_we_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.mode = m;
    @(posedge clk_i);
  endtask

  logic signed [31:0] directed[] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd32768, 32'sd32769,
    32'sd65536, -32'sd65536, 32'sd2097152, -32'sd2097152, 32'sd1048576, -32'sd1048576
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset mode is linear: a few values before any write
    for (int i = 0; i < 4; i++) send_value(directed[i]);
    drain();
    for (int p = 0; p < 8; p++) begin
      write_mode(p[2:0]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (p == 4) hold_req = 1'b1;
      foreach (directed[i]) send_value(directed[i]);
      for (int i = 0; i < PHASE_RAND; i++) send_value(pick_value());
      drain();
    end
    // back to an extreme and the reset value
    write_mode(MODE_IDENT_B);
    for (int i = 0; i < 20; i++) send_value(pick_value());
    drain();
    write_mode(adu_pkg::MODE_LINEAR);
    for (int i = 0; i < 20; i++) send_value(pick_value());
    drain();
    $display("sent %0d values over all eight mode codes, %0d results checked", sent, sb.checked);
    $display("idle patterns: none, sender, receiver, both, plus one long output hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_activation_and_derivative_unit: clean");
    end else begin
      $display("tb_activation_and_derivative_unit: errors");
    end
    $finish;
  end
endmodule
